[hw/rtl/segment_intersection_test_defines.svh]
// assertion macros for the segment intersection test
`ifndef SEGMENT_INTERSECTION_TEST_DEFINES_SVH
`define SEGMENT_INTERSECTION_TEST_DEFINES_SVH

`ifndef ASSERT_OFF
`define SEGINT_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
`define SEGINT_ASSERT_RST(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define SEGINT_ASSERT(lbl, prop, msg)
`define SEGINT_ASSERT_RST(lbl, prop, msg)
`endif

`endif

[hw/rtl/segint_pkg.sv]
// shared constants and types for the segment intersection test
`default_nettype none
package segint_pkg;

  localparam int FIELD_BITS      = 32;
  localparam int COORD_BITS_DEF  = 32;
  localparam int NUM_FIELDS      = 8;

  localparam int IDX_FIRST_START_X  = 0;
  localparam int IDX_FIRST_START_Y  = 1;
  localparam int IDX_FIRST_END_X    = 2;
  localparam int IDX_FIRST_END_Y    = 3;
  localparam int IDX_SECOND_START_X = 4;
  localparam int IDX_SECOND_START_Y = 5;
  localparam int IDX_SECOND_END_X   = 6;
  localparam int IDX_SECOND_END_Y   = 7;

  typedef struct packed {
    logic neg;
    logic zero;
    logic on_seg;
  } side_t;

endpackage
`default_nettype wire

[hw/rtl/segint_side.sv]
// side of a point against a segment's line, and point-on-segment flag
`default_nettype none
module segint_side #(
  parameter int COORD_BITS = segint_pkg::COORD_BITS_DEF
) (
  input  wire logic signed [COORD_BITS-1:0] ax,
  input  wire logic signed [COORD_BITS-1:0] ay,
  input  wire logic signed [COORD_BITS-1:0] bx,
  input  wire logic signed [COORD_BITS-1:0] by,
  input  wire logic signed [COORD_BITS-1:0] px,
  input  wire logic signed [COORD_BITS-1:0] py,
  output segint_pkg::side_t                 side
);
  import segint_pkg::*;

  localparam int D = COORD_BITS + 1;
  localparam int P = 2 * D;

  logic signed [D-1:0] dx;
  logic signed [D-1:0] dy;
  logic signed [D-1:0] dpx;
  logic signed [D-1:0] dpy;
  logic signed [P-1:0] m1;
  logic signed [P-1:0] m2;
  logic signed [P:0]   cross_prod;
  logic                in_x;
  logic                in_y;

  assign dx  = {bx[COORD_BITS-1], bx} - {ax[COORD_BITS-1], ax};
  assign dy  = {by[COORD_BITS-1], by} - {ay[COORD_BITS-1], ay};
  assign dpx = {px[COORD_BITS-1], px} - {ax[COORD_BITS-1], ax};
  assign dpy = {py[COORD_BITS-1], py} - {ay[COORD_BITS-1], ay};

  assign m1         = P'(dx) * P'(dpy);
  assign m2         = P'(dy) * P'(dpx);
  assign cross_prod = (P+1)'(m1) - (P+1)'(m2);

  // closed span tests
  assign in_x = (ax < bx) ? (px >= ax && px <= bx) : (px >= bx && px <= ax);
  assign in_y = (ay < by) ? (py >= ay && py <= by) : (py >= by && py <= ay);

  always_comb begin
    side.neg  = cross_prod[P];
    side.zero = (cross_prod == '0);
    if (ax != bx) begin
      side.on_seg = side.zero && in_x;
    end else if (ay != by) begin
      side.on_seg = side.zero && in_y;
    end else begin
      side.on_seg = 1'b0;
    end
  end

endmodule
`default_nettype wire

[hw/rtl/segint_eval.sv]
// intersection decision from four side tests
`default_nettype none
module segint_eval #(
  parameter int COORD_BITS = segint_pkg::COORD_BITS_DEF
) (
  input  wire logic [segint_pkg::FIELD_BITS-1:0] fld [segint_pkg::NUM_FIELDS],
  output logic                                   touches
);
  import segint_pkg::*;

  logic signed [COORD_BITS-1:0] c [NUM_FIELDS];
  side_t s_b1;
  side_t s_b2;
  side_t s_a1;
  side_t s_a2;

  // low coordinate bits, sign taken from the top kept bit; wider coordinates are zero-extended
  for (genvar i = 0; i < NUM_FIELDS; i++) begin : g_coord
    if (COORD_BITS <= FIELD_BITS) begin : g_trunc
      assign c[i] = fld[i][COORD_BITS-1:0];
    end else begin : g_ext
      assign c[i] = {{(COORD_BITS-FIELD_BITS){1'b0}}, fld[i]};
    end
  end

  segint_side #(.COORD_BITS(COORD_BITS)) u_side_b1 (
    .ax(c[IDX_FIRST_START_X]), .ay(c[IDX_FIRST_START_Y]),
    .bx(c[IDX_FIRST_END_X]),   .by(c[IDX_FIRST_END_Y]),
    .px(c[IDX_SECOND_START_X]), .py(c[IDX_SECOND_START_Y]),
    .side(s_b1)
  );

  segint_side #(.COORD_BITS(COORD_BITS)) u_side_b2 (
    .ax(c[IDX_FIRST_START_X]), .ay(c[IDX_FIRST_START_Y]),
    .bx(c[IDX_FIRST_END_X]),   .by(c[IDX_FIRST_END_Y]),
    .px(c[IDX_SECOND_END_X]),  .py(c[IDX_SECOND_END_Y]),
    .side(s_b2)
  );

  segint_side #(.COORD_BITS(COORD_BITS)) u_side_a1 (
    .ax(c[IDX_SECOND_START_X]), .ay(c[IDX_SECOND_START_Y]),
    .bx(c[IDX_SECOND_END_X]),   .by(c[IDX_SECOND_END_Y]),
    .px(c[IDX_FIRST_START_X]),  .py(c[IDX_FIRST_START_Y]),
    .side(s_a1)
  );

  segint_side #(.COORD_BITS(COORD_BITS)) u_side_a2 (
    .ax(c[IDX_SECOND_START_X]), .ay(c[IDX_SECOND_START_Y]),
    .bx(c[IDX_SECOND_END_X]),   .by(c[IDX_SECOND_END_Y]),
    .px(c[IDX_FIRST_END_X]),    .py(c[IDX_FIRST_END_Y]),
    .side(s_a2)
  );

  always_comb begin
    touches = s_b1.on_seg || s_b2.on_seg || s_a1.on_seg || s_a2.on_seg ||
              (({s_b1.neg, s_b1.zero} != {s_b2.neg, s_b2.zero}) &&
               ({s_a1.neg, s_a1.zero} != {s_a2.neg, s_a2.zero}));
  end

endmodule
`default_nettype wire

[hw/rtl/segment_intersection_test.sv]
// segment intersection test: input register, evaluation, result register
// throughput: one segment pair per cycle while out_ready is high, set by the single evaluation stage
//   between the input register and the result register
// the input register takes a new beat while a finished result waits only if the input register is empty
// reset: synchronous, clears both stage valid flags; payload is not reset
`default_nettype none
`include "segment_intersection_test_defines.svh"
module segment_intersection_test #(
  parameter int COORD_BITS = segint_pkg::COORD_BITS_DEF
) (
  input  wire logic                                  clk,
  input  wire logic                                  rst,
  input  wire logic                                  in_valid,
  output logic                                       in_ready,
  input  wire logic signed [segint_pkg::FIELD_BITS-1:0] first_start_x,
  input  wire logic signed [segint_pkg::FIELD_BITS-1:0] first_start_y,
  input  wire logic signed [segint_pkg::FIELD_BITS-1:0] first_end_x,
  input  wire logic signed [segint_pkg::FIELD_BITS-1:0] first_end_y,
  input  wire logic signed [segint_pkg::FIELD_BITS-1:0] second_start_x,
  input  wire logic signed [segint_pkg::FIELD_BITS-1:0] second_start_y,
  input  wire logic signed [segint_pkg::FIELD_BITS-1:0] second_end_x,
  input  wire logic signed [segint_pkg::FIELD_BITS-1:0] second_end_y,
  output logic                                       out_valid,
  input  wire logic                                  out_ready,
  output logic                                       touches
);
  import segint_pkg::*;

  logic                  s1_valid;
  logic [FIELD_BITS-1:0] s1_fld [NUM_FIELDS];
  logic                  eval_touches;
  logic                  out_load;

  // result stage can take a beat when empty or draining
  assign out_load = !out_valid || out_ready;
  assign in_ready = !s1_valid || out_load;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_ready) begin
      s1_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      s1_fld[IDX_FIRST_START_X]  <= first_start_x;
      s1_fld[IDX_FIRST_START_Y]  <= first_start_y;
      s1_fld[IDX_FIRST_END_X]    <= first_end_x;
      s1_fld[IDX_FIRST_END_Y]    <= first_end_y;
      s1_fld[IDX_SECOND_START_X] <= second_start_x;
      s1_fld[IDX_SECOND_START_Y] <= second_start_y;
      s1_fld[IDX_SECOND_END_X]   <= second_end_x;
      s1_fld[IDX_SECOND_END_Y]   <= second_end_y;
    end
  end

  segint_eval #(.COORD_BITS(COORD_BITS)) u_eval (
    .fld     (s1_fld),
    .touches (eval_touches)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load && s1_valid) begin
      touches <= eval_touches;
    end
  end

  `SEGINT_ASSERT_RST(a_reset_clears, $past(rst) |-> (!s1_valid && !out_valid), "valid after reset")
  `SEGINT_ASSERT(a_accept_fills, (in_valid && in_ready) |=> s1_valid, "accepted beat lost")
  `SEGINT_ASSERT(a_stage_moves, (s1_valid && out_load) |=> out_valid, "stage beat not forwarded")
  `SEGINT_ASSERT(a_drain_empty, (out_valid && out_ready && !s1_valid) |=> !out_valid, "result repeated")

endmodule
`default_nettype wire
